// File: design/tti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_pkg
// Shared constants, types and the divider threshold table for the thermistor
// table interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int FIXED_RESISTOR_OHMS = 10000;
  localparam int TABLE_ENTRIES       = 206;
  localparam int KNOWN_RES           = 206;
  localparam int LOW_DEG             = 55;
  localparam int CODE_FULL_Q4        = 65520;

  // field widths
  localparam int CODE_W    = 12;
  localparam int CODE_Q4_W = CODE_W + 4;
  localparam int TH_W      = 16;
  localparam int TEMP_W    = 17;
  localparam int STATUS_W  = 2;

  // table addressing
  localparam int ROM_AW    = $clog2(TABLE_ENTRIES);
  localparam int ROM_DEPTH = 1 << ROM_AW;
  localparam int IDX_W     = $clog2(TABLE_ENTRIES + 1);

  // table restoring divider
  localparam int CNT_W     = 4;
  localparam int TAB_QBITS = 8;

  // linear adapter: t = floor((509696 * code + 259213539) / 87750) - 8192
  // 48945 / 2^32 sits just under 1 / 87750, so the quotient estimate is exact or one low
  localparam int LIN_N_W     = 32;
  localparam int LIN_SLOPE_W = 19;
  localparam int LIN_RECIP_W = 16;
  localparam int LIN_P_W     = LIN_N_W + LIN_RECIP_W;
  localparam int LIN_SHIFT   = 32;
  localparam int LIN_Q_W     = 15;
  localparam int LIN_REM_W   = 18;
  localparam logic [LIN_SLOPE_W-1:0] LIN_SLOPE   = LIN_SLOPE_W'(509696);
  localparam logic [LIN_N_W-1:0]     LIN_OFFSET  = LIN_N_W'(259213539);
  localparam logic [LIN_REM_W-1:0]   LIN_DIVISOR = LIN_REM_W'(87750);
  localparam logic [LIN_RECIP_W-1:0] LIN_RECIP   = LIN_RECIP_W'(48945);
  localparam logic [TEMP_W-1:0]      LIN_BIAS    = TEMP_W'(8192);

  // table result
  localparam logic [TEMP_W-1:0] DEG_OFFSET = TEMP_W'(LOW_DEG + 1);
  localparam logic [TEMP_W-1:0] TEMP_BELOW = TEMP_W'(-LOW_DEG * 256);
  localparam logic [TEMP_W-1:0] TEMP_ABOVE = TEMP_W'((TABLE_ENTRIES - 1 - LOW_DEG) * 256);

  // range status codes
  localparam logic [STATUS_W-1:0] ST_IN_RANGE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BELOW    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE    = 2'd2;

  // result select codes
  localparam logic [1:0] RES_TABLE  = 2'd0;
  localparam logic [1:0] RES_LINEAR = 2'd1;
  localparam logic [1:0] RES_BELOW  = 2'd2;
  localparam logic [1:0] RES_ABOVE  = 2'd3;

  typedef struct packed {
    logic       load_input;
    logic       lin_mult;
    logic       lin_est;
    logic       lin_rem;
    logic       search_step;
    logic       fetch;
    logic       tab_setup;
    logic       div_step;
    logic       load_result;
    logic [1:0] result_sel;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic search_done;
    logic above;
    logic below;
    logic out_free;
  } status_t;

  typedef logic [TH_W-1:0] rom_t [ROM_DEPTH];

  // thermistor resistance per degree from the lowest table temperature, centiohms
  localparam logic [31:0] RES_CENTI [KNOWN_RES] = '{
    32'd96384933, 32'd89531887, 32'd83210829, 32'd77377165, 32'd71990328, 32'd67013366,
    32'd62412596, 32'd58157300, 32'd54219446, 32'd50573438, 32'd47195891, 32'd44065427,
    32'd41162495, 32'd38469200, 32'd35969155, 32'd33647350, 32'd31490023, 32'd29484552,
    32'd27619356, 32'd25883800, 32'd24268116, 32'd22763325, 32'd21361171, 32'd20054058,
    32'd18834994, 32'd17697541, 32'd16635765, 32'd15644197, 32'd14717792, 32'd13851896,
    32'd13042213, 32'd12284774, 32'd11575911, 32'd10912235, 32'd10290611, 32'd9708138,
    32'd9162130, 32'd8650100, 32'd8169745, 32'd7718928, 32'd7295670, 32'd6898132,
    32'd6524610, 32'd6173520, 32'd5843393, 32'd5532860, 32'd5240653, 32'd4965589,
    32'd4706570, 32'd4462572, 32'd4232642, 32'd4015895, 32'd3811502, 32'd3618693,
    32'd3436650, 32'd3265000, 32'd3102925, 32'd2949839, 32'd2805195, 32'd2668481,
    32'd2539219, 32'd2416964, 32'd2301298, 32'd2191831, 32'd2088197, 32'd1990054,
    32'd1897082, 32'd1808982, 32'd1725473, 32'd1646290, 32'd1571188, 32'd1499934,
    32'd1432312, 32'd1368117, 32'd1307157, 32'd1249253, 32'd1194236, 32'd1141948,
    32'd1092237, 32'd1044966, 32'd1000000, 32'd957216, 32'd916498, 32'd877734,
    32'd840821, 32'd805661, 32'd772163, 32'd740239, 32'd709807, 32'd680791,
    32'd653117, 32'd626717, 32'd601525, 32'd577480, 32'd554525, 32'd532604,
    32'd511667, 32'd491663, 32'd472547, 32'd454275, 32'd436806, 32'd420100,
    32'd404121, 32'd388833, 32'd374203, 32'd360200, 32'd346793, 32'd333955,
    32'd321659, 32'd309879, 32'd298591, 32'd287772, 32'd277400, 32'd267455,
    32'd257918, 32'd248769, 32'd239991, 32'd231568, 32'd223483, 32'd215721,
    32'd208267, 32'd201109, 32'd194232, 32'd187625, 32'd181276, 32'd175173,
    32'd169306, 32'd163665, 32'd158240, 32'd153021, 32'd148000, 32'd143169,
    32'd138499, 32'd134017, 32'd129704, 32'd125551, 32'd121554, 32'd117704,
    32'd113997, 32'd110425, 32'd106984, 32'd103668, 32'd100471, 32'd97389,
    32'd94418, 32'd91552, 32'd88788, 32'd86121, 32'd83548, 32'd81064,
    32'd78667, 32'd76352, 32'd74118, 32'd71959, 32'd69874, 32'd67860,
    32'd65914, 32'd64033, 32'd62215, 32'd60457, 32'd58758, 32'd57114,
    32'd55525, 32'd53987, 32'd52499, 32'd51060, 32'd49666, 32'd48318,
    32'd47012, 32'd45748, 32'd44524, 32'd43338, 32'd42190, 32'd41077,
    32'd39999, 32'd38954, 32'd37941, 32'd36960, 32'd36008, 32'd35085,
    32'd34190, 32'd33322, 32'd32480, 32'd31663, 32'd30870, 32'd30101,
    32'd29355, 32'd28630, 32'd27926, 32'd27243, 32'd26580, 32'd25936,
    32'd25310, 32'd24702, 32'd24112, 32'd23538, 32'd22980, 32'd22438,
    32'd21912, 32'd21400, 32'd20902, 32'd20417, 32'd19947, 32'd19489,
    32'd19043, 32'd18610
  };

  // long division by shift and subtract, for building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Divider thresholds in Q12.4 code units; entries past the list repeat the last one.
  function automatic rom_t build_rom();
    rom_t r;
    logic [63:0] rf;
    logic [63:0] den;
    logic [63:0] th;
    int src;
    rf = 64'(FIXED_RESISTOR_OHMS) * 64'd100;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      src = (k < KNOWN_RES) ? k : KNOWN_RES - 1;
      den = rf + 64'(RES_CENTI[src]);
      th  = udiv64(64'(CODE_FULL_Q4) * rf + (den >> 1), den);
      if (th > 64'hFFFF) begin
        th = 64'hFFFF;
      end
      r[k] = th[TH_W-1:0];
    end
    return r;
  endfunction

  localparam rom_t DIV_ROM = build_rom();

endpackage

// File: design/tti_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_ctrl
// Sequencer: binary search, threshold fetch, table divider, linear steps and
// result hand-off.
// ----------------------------------------------------------------------------
module tti_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  tti_pkg::status_t status,
  output tti_pkg::cmd_t    cmd
);
  import tti_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LIN_MUL  = 4'd1;
  localparam logic [3:0] S_LIN_EST  = 4'd2;
  localparam logic [3:0] S_LIN_REM  = 4'd3;
  localparam logic [3:0] S_SEARCH   = 4'd4;
  localparam logic [3:0] S_FETCH    = 4'd5;
  localparam logic [3:0] S_TAB_LOAD = 4'd6;
  localparam logic [3:0] S_DIVIDE   = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [1:0]       sel;
  logic [1:0]       sel_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    cmd        = '0;
    cmd.result_sel = sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_input = 1'b1;
          state_next = status.mode ? S_LIN_MUL : S_SEARCH;
        end
      end
      S_LIN_MUL: begin
        cmd.lin_mult = 1'b1;
        state_next   = S_LIN_EST;
      end
      S_LIN_EST: begin
        cmd.lin_est = 1'b1;
        state_next  = S_LIN_REM;
      end
      S_LIN_REM: begin
        cmd.lin_rem = 1'b1;
        sel_next   = RES_LINEAR;
        state_next = S_DONE;
      end
      S_SEARCH: begin
        if (!status.search_done) begin
          cmd.search_step = 1'b1;
        end else if (status.above) begin
          sel_next   = RES_ABOVE;
          state_next = S_DONE;
        end else if (status.below) begin
          sel_next   = RES_BELOW;
          state_next = S_DONE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_TAB_LOAD;
      end
      S_TAB_LOAD: begin
        cmd.tab_setup = 1'b1;
        cnt_next   = CNT_W'(TAB_QBITS - 1);
        sel_next   = RES_TABLE;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      sel   <= RES_TABLE;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
    end
  end

endmodule

// File: design/tti_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_datapath
// Mode register, search bounds, threshold table, restoring divider, linear
// reciprocal path and output register.
// ----------------------------------------------------------------------------
module tti_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 conversion_mode,
  input  logic [tti_pkg::CODE_W-1:0]           adc_code,
  input  tti_pkg::cmd_t                        cmd,
  output tti_pkg::status_t                     status,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tti_pkg::TEMP_W-1:0]    temperature_q8,
  output logic [tti_pkg::STATUS_W-1:0]         range_status
);
  import tti_pkg::*;

  logic                   mode;
  logic [CODE_W-1:0]      code;
  logic [CODE_Q4_W-1:0]   code_q4;
  logic [IDX_W-1:0]       s_lo;
  logic [IDX_W-1:0]       s_hi;
  logic [IDX_W:0]         mid_sum;
  logic [IDX_W-1:0]       mid;
  logic [IDX_W-1:0]       hi_m1;
  logic [TH_W-1:0]        rom_mid;
  logic [TH_W-1:0]        th_lo;
  logic [TH_W-1:0]        th_hi;
  logic [LIN_N_W-1:0]     lin_num;
  logic [LIN_P_W-1:0]     lin_prod;
  logic [LIN_Q_W-1:0]     lin_q;
  logic [LIN_N_W-1:0]     lin_back;
  logic [LIN_N_W-1:0]     lin_diff;
  logic [LIN_REM_W-1:0]   lin_rem;
  logic [LIN_Q_W-1:0]     lin_quo;
  logic [TH_W-1:0]        rem;
  logic [TH_W-1:0]        divisor;
  logic [TAB_QBITS-1:0]   quo;
  logic [TH_W:0]          trial;
  logic [TH_W:0]          trial_diff;
  logic                   fits;
  logic [TEMP_W-1:0]      temp_sel;
  logic [STATUS_W-1:0]    status_sel;

  assign code_q4 = {code, 4'b0000};
  assign mid_sum = {1'b0, s_lo} + {1'b0, s_hi};
  assign mid     = mid_sum[IDX_W:1];
  assign hi_m1   = s_hi - IDX_W'(1);
  assign rom_mid = DIV_ROM[mid[ROM_AW-1:0]];

  // quotient estimate is exact or one low; the remainder check settles it
  assign lin_prod = LIN_P_W'(lin_num) * LIN_P_W'(LIN_RECIP);
  assign lin_back = LIN_N_W'(lin_q) * LIN_N_W'(LIN_DIVISOR);
  assign lin_diff = lin_num - lin_back;
  assign lin_quo  = lin_q + LIN_Q_W'(lin_rem >= LIN_DIVISOR);

  assign trial      = {rem, 1'b0};
  assign trial_diff = trial - {1'b0, divisor};
  assign fits       = (trial >= {1'b0, divisor});

  assign status.mode        = mode;
  assign status.search_done = (s_lo == s_hi);
  assign status.above       = (s_hi == IDX_W'(TABLE_ENTRIES));
  assign status.below       = (s_hi == '0);
  assign status.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid) begin
      mode <= conversion_mode;
    end
  end

  // search for the first threshold above the scaled code
  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      code <= adc_code;
      s_lo <= '0;
      s_hi <= IDX_W'(TABLE_ENTRIES);
    end else if (cmd.search_step) begin
      if (code_q4 < rom_mid) begin
        s_hi <= mid;
      end else begin
        s_lo <= mid + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      th_lo <= DIV_ROM[hi_m1[ROM_AW-1:0]];
      th_hi <= DIV_ROM[s_hi[ROM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lin_mult) begin
      lin_num <= LIN_N_W'(code) * LIN_N_W'(LIN_SLOPE) + LIN_OFFSET;
    end
    if (cmd.lin_est) begin
      lin_q <= lin_prod[LIN_SHIFT +: LIN_Q_W];
    end
    if (cmd.lin_rem) begin
      lin_rem <= lin_diff[LIN_REM_W-1:0];
    end
  end

  // one fraction bit per step; the remainder always stays below the span
  always_ff @(posedge clk) begin
    if (cmd.tab_setup) begin
      rem     <= code_q4 - th_lo;
      divisor <= th_hi - th_lo;
      quo     <= '0;
    end else if (cmd.div_step) begin
      rem <= fits ? trial_diff[TH_W-1:0] : trial[TH_W-1:0];
      quo <= {quo[TAB_QBITS-2:0], fits};
    end
  end

  always_comb begin
    case (cmd.result_sel)
      RES_TABLE: begin
        temp_sel   = ((TEMP_W'(s_hi) - DEG_OFFSET) << 8) + TEMP_W'(quo);
        status_sel = ST_IN_RANGE;
      end
      RES_LINEAR: begin
        temp_sel   = TEMP_W'(lin_quo) - LIN_BIAS;
        status_sel = ST_IN_RANGE;
      end
      RES_BELOW: begin
        temp_sel   = TEMP_BELOW;
        status_sel = ST_BELOW;
      end
      RES_ABOVE: begin
        temp_sel   = TEMP_ABOVE;
        status_sel = ST_ABOVE;
      end
      default: begin
        temp_sel   = TEMP_BELOW;
        status_sel = ST_IN_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      temperature_q8 <= signed'(temp_sel);
      range_status   <= status_sel;
    end
  end

endmodule

// File: design/thermistor_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_table_interpolator
// Converts a 12-bit ADC code to Celsius in Q8, by divider table interpolation
// or by the linear adapter line.
// ----------------------------------------------------------------------------
// One sample is worked at a time. In table mode a binary search makes seven or
// eight probes of the constant threshold table, the fetch and table-load states
// read the neighboring thresholds and set up the divider, and eight
// one-bit-per-cycle divider steps give the fraction; a saturated result skips
// the fetch and the divider. Linear mode takes a multiply-add, a reciprocal
// estimate of the quotient and a remainder check. in_stall stays high until
// the result is in the output register, so the next sample can follow in the
// cycle after the result is loaded; a result waiting there does not block the
// next sample, but a stalled output register holds the block in its last step.
// cfg_ready is always high; write conversion_mode only while the block is idle.
module thermistor_table_interpolator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 conversion_mode,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tti_pkg::CODE_W-1:0]           adc_code,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tti_pkg::TEMP_W-1:0]    temperature_q8,
  output logic [tti_pkg::STATUS_W-1:0]         range_status
);
  import tti_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tti_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .conversion_mode (conversion_mode),
    .adc_code        (adc_code),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .temperature_q8  (temperature_q8),
    .range_status    (range_status)
  );

endmodule

// File: design/tti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tti_checker
// Port-level checks for the thermistor table interpolator.
// ----------------------------------------------------------------------------
module tti_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [tti_pkg::TEMP_W-1:0]    temperature_q8,
  input logic [tti_pkg::STATUS_W-1:0]         range_status
);
  import tti_pkg::*;

  // a sample in work blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (range_status == ST_IN_RANGE || range_status == ST_BELOW ||
                   range_status == ST_ABOVE))
    else $error("undefined range status");

  a_below_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_status == ST_BELOW |-> temperature_q8 == signed'(TEMP_BELOW))
    else $error("below-range result not saturated to table minimum");

  a_above_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_status == ST_ABOVE |-> temperature_q8 == signed'(TEMP_ABOVE))
    else $error("above-range result not saturated to table maximum");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(temperature_q8) &&
                               $stable(range_status))
    else $error("stalled result changed");

endmodule

bind thermistor_table_interpolator tti_checker u_tti_checker (.*);
